// ===== src/bilin_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bilin_pkg
// Shared constants and types of the bilinear interpolator.
// ---------------------------------------------------------------------------
package bilin_pkg;

    localparam int COORD_BITS = 24;
    localparam int VALUE_BITS = 32;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_DEGENERATE = 2'd1,
        STATUS_SATURATED  = 2'd2
    } status_t;

endpackage
`default_nettype wire

// ===== src/bilin_if.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bilin_in_if / bilin_out_if
// Valid/ready channels for cell queries and interpolation results.
// ---------------------------------------------------------------------------
interface bilin_in_if #(
    parameter int COORD_BITS = bilin_pkg::COORD_BITS,
    parameter int VALUE_BITS = bilin_pkg::VALUE_BITS
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] cell_x_low;
    logic signed [COORD_BITS-1:0] cell_y_low;
    logic signed [COORD_BITS-1:0] cell_x_high;
    logic signed [COORD_BITS-1:0] cell_y_high;
    logic signed [VALUE_BITS-1:0] corner_value_ll;
    logic signed [VALUE_BITS-1:0] corner_value_hl;
    logic signed [VALUE_BITS-1:0] corner_value_lh;
    logic signed [VALUE_BITS-1:0] corner_value_hh;
    logic signed [COORD_BITS-1:0] query_x;
    logic signed [COORD_BITS-1:0] query_y;

    modport source (
        output valid, cell_x_low, cell_y_low, cell_x_high, cell_y_high,
               corner_value_ll, corner_value_hl, corner_value_lh, corner_value_hh,
               query_x, query_y,
        input  ready
    );
    modport sink (
        input  valid, cell_x_low, cell_y_low, cell_x_high, cell_y_high,
               corner_value_ll, corner_value_hl, corner_value_lh, corner_value_hh,
               query_x, query_y,
        output ready
    );
endinterface

interface bilin_out_if #(
    parameter int VALUE_BITS = bilin_pkg::VALUE_BITS
);
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] interpolated_value;
    logic [1:0]                   result_status;

    modport source (output valid, interpolated_value, result_status, input ready);
    modport sink (input valid, interpolated_value, result_status, output ready);
endinterface
`default_nettype wire

// ===== src/bilinear_interpolator.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// bilinear_interpolator
// Bilinear interpolation over one grid cell, rounded half away from zero.
// Pipeline: eight arithmetic stages, one restoring-divider stage per quotient
// bit, and one rounding/output stage.
// Throughput: one transfer per cycle; a stalled output freezes the whole pipe.
// Reset clears all stage valid bits; payload registers are not reset.
// ---------------------------------------------------------------------------
module bilinear_interpolator #(
    parameter int COORD_BITS = bilin_pkg::COORD_BITS,
    parameter int VALUE_BITS = bilin_pkg::VALUE_BITS
) (
    input  wire         clk,
    input  wire         rst_n,
    bilin_in_if.sink    in_ch,
    bilin_out_if.source out_ch
);

    localparam int C  = COORD_BITS;
    localparam int V  = VALUE_BITS;
    localparam int L  = C + 1;          // low slice of a weight
    localparam int W  = 2 * C + 2;      // weight width
    localparam int DW = 2 * C;          // denominator width
    localparam int NW = V + 2 * C + 4;  // numerator width

    logic adv;
    logic out_valid_reg;

    assign adv         = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = adv;

    // ---------------- stage 1: coordinate differences ----------------
    logic                s1_valid_reg;
    logic signed [C:0]   ax_reg, bx_reg, ay_reg, by_reg;
    logic [C-1:0]        dxm_reg, dym_reg;
    logic                s1_dneg_reg, s1_degen_reg;
    logic signed [V-1:0] s1_v_reg [4];

    logic signed [C:0] x1e, y1e, x2e, y2e, xe, ye, dx, dy;
    logic signed [C:0] dx_abs, dy_abs;

    always_comb
    begin
        x1e    = {in_ch.cell_x_low[C-1], in_ch.cell_x_low};
        y1e    = {in_ch.cell_y_low[C-1], in_ch.cell_y_low};
        x2e    = {in_ch.cell_x_high[C-1], in_ch.cell_x_high};
        y2e    = {in_ch.cell_y_high[C-1], in_ch.cell_y_high};
        xe     = {in_ch.query_x[C-1], in_ch.query_x};
        ye     = {in_ch.query_y[C-1], in_ch.query_y};
        dx     = x2e - x1e;
        dy     = y2e - y1e;
        dx_abs = dx[C] ? -dx : dx;
        dy_abs = dy[C] ? -dy : dy;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_reg       <= x2e - xe;
            bx_reg       <= xe - x1e;
            ay_reg       <= y2e - ye;
            by_reg       <= ye - y1e;
            dxm_reg      <= dx_abs[C-1:0];
            dym_reg      <= dy_abs[C-1:0];
            s1_dneg_reg  <= dx[C] ^ dy[C];
            s1_degen_reg <= (dx == '0) || (dy == '0);
            s1_v_reg[0]  <= in_ch.corner_value_ll;
            s1_v_reg[1]  <= in_ch.corner_value_hl;
            s1_v_reg[2]  <= in_ch.corner_value_lh;
            s1_v_reg[3]  <= in_ch.corner_value_hh;
        end
    end

    // ---------------- stage 2: area weights and denominator ----------------
    logic                s2_valid_reg;
    logic signed [W-1:0] w_reg [4];
    logic [DW-1:0]       s2_den_reg;
    logic                s2_dneg_reg, s2_degen_reg;
    logic signed [V-1:0] s2_v_reg [4];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            w_reg[0]     <= ax_reg * ay_reg;
            w_reg[1]     <= bx_reg * ay_reg;
            w_reg[2]     <= ax_reg * by_reg;
            w_reg[3]     <= bx_reg * by_reg;
            s2_den_reg   <= dxm_reg * dym_reg;
            s2_dneg_reg  <= s1_dneg_reg;
            s2_degen_reg <= s1_degen_reg;
            s2_v_reg     <= s1_v_reg;
        end
    end

    // ---------------- stage 3: partial products ----------------
    logic                    s3_valid_reg;
    logic signed [V+L:0]     plo_reg [4];
    logic signed [V+W-L-1:0] phi_reg [4];
    logic [DW-1:0]           s3_den_reg;
    logic                    s3_dneg_reg, s3_degen_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
            begin
                plo_reg[i] <= s2_v_reg[i] * $signed({1'b0, w_reg[i][L-1:0]});
                phi_reg[i] <= s2_v_reg[i] * $signed(w_reg[i][W-1:L]);
            end
            s3_den_reg   <= s2_den_reg;
            s3_dneg_reg  <= s2_dneg_reg;
            s3_degen_reg <= s2_degen_reg;
        end
    end

    // ---------------- stage 4: full terms ----------------
    logic                 s4_valid_reg;
    logic signed [NW-1:0] term_reg [4];
    logic [DW-1:0]        s4_den_reg;
    logic                 s4_dneg_reg, s4_degen_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
                term_reg[i] <= (NW'(phi_reg[i]) <<< L) + NW'(plo_reg[i]);
            s4_den_reg   <= s3_den_reg;
            s4_dneg_reg  <= s3_dneg_reg;
            s4_degen_reg <= s3_degen_reg;
        end
    end

    // ---------------- stage 5/6: numerator sum ----------------
    logic                 s5_valid_reg, s6_valid_reg;
    logic signed [NW-1:0] pair_reg [2];
    logic signed [NW-1:0] num_reg;
    logic [DW-1:0]        s5_den_reg, s6_den_reg;
    logic                 s5_dneg_reg, s5_degen_reg, s6_dneg_reg, s6_degen_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pair_reg[0]  <= term_reg[0] + term_reg[1];
            pair_reg[1]  <= term_reg[2] + term_reg[3];
            s5_den_reg   <= s4_den_reg;
            s5_dneg_reg  <= s4_dneg_reg;
            s5_degen_reg <= s4_degen_reg;
            num_reg      <= pair_reg[0] + pair_reg[1];
            s6_den_reg   <= s5_den_reg;
            s6_dneg_reg  <= s5_dneg_reg;
            s6_degen_reg <= s5_degen_reg;
        end
    end

    // ---------------- stage 7: magnitude and result sign ----------------
    logic          s7_valid_reg;
    logic [NW-1:0] mag_reg;
    logic [DW-1:0] s7_den_reg;
    logic          s7_neg_reg, s7_degen_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mag_reg      <= num_reg[NW-1] ? $unsigned(-num_reg) : $unsigned(num_reg);
            s7_neg_reg   <= num_reg[NW-1] ^ s6_dneg_reg;
            s7_den_reg   <= s6_den_reg;
            s7_degen_reg <= s6_degen_reg;
        end
    end

    // ---------------- stage 8 and divider stages ----------------
    // Index 0 is the divider setup stage; index k+1 holds k+1 quotient bits.
    logic          dv_valid_reg [V+1];
    logic [DW-1:0] dv_rem_reg   [V+1];
    logic [V-1:0]  dv_low_reg   [V+1];
    logic [V-1:0]  dv_q_reg     [V+1];
    logic [DW-1:0] dv_den_reg   [V+1];
    logic          dv_neg_reg   [V+1];
    logic          dv_sat_reg   [V+1];
    logic          dv_degen_reg [V+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            // Quotient of more than V bits overflows every output limit.
            dv_sat_reg[0]   <= mag_reg >= NW'({s7_den_reg, {V{1'b0}}});
            dv_rem_reg[0]   <= mag_reg[V+DW-1:V];
            dv_low_reg[0]   <= mag_reg[V-1:0];
            dv_q_reg[0]     <= '0;
            dv_den_reg[0]   <= s7_den_reg;
            dv_neg_reg[0]   <= s7_neg_reg;
            dv_degen_reg[0] <= s7_degen_reg;
        end
    end

    for (genvar k = 0; k < V; k++)
    begin : g_div
        logic [DW:0] trial;
        logic        ge;

        always_comb
        begin
            trial = {dv_rem_reg[k], dv_low_reg[k][V-1]};
            ge    = trial >= {1'b0, dv_den_reg[k]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_valid_reg[k+1] <= 1'b0;
            else if (adv)
                dv_valid_reg[k+1] <= dv_valid_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_rem_reg[k+1]   <= ge ? DW'(trial - {1'b0, dv_den_reg[k]}) : trial[DW-1:0];
                dv_low_reg[k+1]   <= {dv_low_reg[k][V-2:0], 1'b0};
                dv_q_reg[k+1]     <= {dv_q_reg[k][V-2:0], ge};
                dv_den_reg[k+1]   <= dv_den_reg[k];
                dv_neg_reg[k+1]   <= dv_neg_reg[k];
                dv_sat_reg[k+1]   <= dv_sat_reg[k];
                dv_degen_reg[k+1] <= dv_degen_reg[k];
            end
        end
    end

    // ---------------- rounding, saturation, output register ----------------
    logic [V:0]            q_round, limit;
    logic                  round_up, neg_f, sat_f;
    logic signed [V-1:0]   value_next;
    bilin_pkg::status_t    status_next;
    logic signed [V-1:0]   value_reg;
    bilin_pkg::status_t    status_reg;

    always_comb
    begin
        round_up = {dv_rem_reg[V], 1'b0} >= {1'b0, dv_den_reg[V]};
        q_round  = {1'b0, dv_q_reg[V]} + (V+1)'(round_up);
        neg_f    = dv_neg_reg[V] && (dv_sat_reg[V] || (q_round != '0));
        limit    = neg_f ? (V+1)'(1) << (V-1) : ((V+1)'(1) << (V-1)) - (V+1)'(1);
        sat_f    = dv_sat_reg[V] || (q_round > limit);
        if (dv_degen_reg[V])
        begin
            value_next  = '0;
            status_next = bilin_pkg::STATUS_DEGENERATE;
        end
        else if (sat_f)
        begin
            value_next  = neg_f ? {1'b1, {(V-1){1'b0}}} : {1'b0, {(V-1){1'b1}}};
            status_next = bilin_pkg::STATUS_SATURATED;
        end
        else
        begin
            value_next  = neg_f ? -$signed(q_round[V-1:0]) : $signed(q_round[V-1:0]);
            status_next = bilin_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            value_reg  <= value_next;
            status_reg <= status_next;
        end
    end

    // ---------------- valid chain ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg    <= 1'b0;
            s2_valid_reg    <= 1'b0;
            s3_valid_reg    <= 1'b0;
            s4_valid_reg    <= 1'b0;
            s5_valid_reg    <= 1'b0;
            s6_valid_reg    <= 1'b0;
            s7_valid_reg    <= 1'b0;
            dv_valid_reg[0] <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg    <= in_ch.valid;
            s2_valid_reg    <= s1_valid_reg;
            s3_valid_reg    <= s2_valid_reg;
            s4_valid_reg    <= s3_valid_reg;
            s5_valid_reg    <= s4_valid_reg;
            s6_valid_reg    <= s5_valid_reg;
            s7_valid_reg    <= s6_valid_reg;
            dv_valid_reg[0] <= s7_valid_reg;
            out_valid_reg   <= dv_valid_reg[V];
        end
    end

    assign out_ch.valid              = out_valid_reg;
    assign out_ch.interpolated_value = value_reg;
    assign out_ch.result_status      = status_reg;

`ifndef SYNTHESIS
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg == bilin_pkg::STATUS_DEGENERATE) |-> value_reg == '0)
        else $error("degenerate result with nonzero value");

    a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (status_reg == bilin_pkg::STATUS_SATURATED)
        |-> (value_reg == {1'b1, {(V-1){1'b0}}}) || (value_reg == {1'b0, {(V-1){1'b1}}}))
        else $error("saturated result not at a range extreme");

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        dv_valid_reg[0] && !dv_sat_reg[0] && !dv_degen_reg[0]
        |-> dv_rem_reg[0] < dv_den_reg[0])
        else $error("divider seed remainder not below denominator");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ch.ready |=> out_valid_reg && $stable(value_reg))
        else $error("stalled result changed");
`endif

endmodule
`default_nettype wire
